@@ rtl/core/bffca_pkg.sv @@
// Shared types and constants for the bitmap first-fit chunk allocator.
// Used by the allocator core and its port checker; depends on nothing.
package bffca_pkg;

  // Field widths of the request and result items.
  localparam int REQ_W       = 13;
  localparam int START_W     = 10;
  localparam int FPAY_W      = 11;
  localparam int STAT_W      = 2;
  localparam int PAY_W       = 11;
  localparam int CNT_W       = 11;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [REQ_W-1:0] MAX_REQUEST = 13'd4096;
  localparam logic [CNT_W-1:0] COUNT_MAX   = 11'd2047;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_BAD_FREE = 2'd2,
    STAT_BAD_REQ  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_WIPE,
    S_IDLE,
    S_DIV,
    S_PREP,
    S_SCAN,
    S_VERIFY,
    S_SET,
    S_CLR,
    S_FINISH
  } state_t;

endpackage

@@ rtl/core/bitmap_first_fit_chunk_allocator.sv @@
// Bitmap first-fit chunk allocator: one byte-wide bitmap memory, one read pipe
// and a sequencer that scans, verifies, sets and clears runs. Uses bffca_pkg.
// An allocate passes S_DIV and S_PREP, scans the map from byte 0 and then sets
// the run it found; a free verifies the run and then clears it. The bitmap read
// port handles one byte a cycle.
// One item at a time: in_tready is low from acceptance until the result is staged.
// After reset the bitmap is wiped (all MAP_BYTES bytes, 128 by default) with in_tready low.
module bitmap_first_fit_chunk_allocator #(
  parameter int NUM_CHUNKS   = 1024,
  parameter int CHUNK_BYTES  = 4,
  parameter int HEADER_BYTES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // request_bytes[12:0], free_start[22:13], free_payload_chunks[33:23], zero pad
  input  logic [bffca_pkg::IN_TDATA_W-1:0]    in_tdata,
  // opcode[0]
  input  logic [0:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status[1:0], run_start[11:2], payload_chunks[22:12], chunks_in_use[33:23], zero pad
  output logic [bffca_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import bffca_pkg::*;

  localparam int MAP_BYTES  = (NUM_CHUNKS + 7) / 8;
  localparam int AW         = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int CLOG_N     = $clog2(NUM_CHUNKS + 1);
  localparam int IW         = (CLOG_N > 12) ? CLOG_N + 1 : 13;
  localparam int HDR_CHUNKS = (HEADER_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
  localparam int LOG_C      = $clog2(CHUNK_BYTES);
  localparam int SHIFT      = REQ_W + LOG_C;
  localparam int PW         = SHIFT + REQ_W;
  localparam int RECIP      = ((1 << SHIFT) + CHUNK_BYTES - 1) / CHUNK_BYTES;

  localparam logic [AW:0] LAST_BYTE = (AW + 1)'(MAP_BYTES - 1);

  state_t              state_r, state_nxt;
  logic [AW:0]         cnt_r, cnt_nxt;
  logic [AW:0]         last_r, last_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       pend_addr_r, pend_addr_nxt;
  logic [IW-1:0]       lo_r, lo_nxt;
  logic [IW-1:0]       hi_r, hi_nxt;
  logic [IW-1:0]       run_r, run_nxt;
  logic [IW-1:0]       total_r, total_nxt;
  logic [REQ_W-1:0]    num_r, num_nxt;
  logic [REQ_W-1:0]    pay_r, pay_nxt;
  logic                op_r, op_nxt;
  logic [FPAY_W-1:0]   fpay_r, fpay_nxt;
  logic                bad_r, bad_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [START_W-1:0]  res_start_r, res_start_nxt;
  logic [PAY_W-1:0]    res_pay_r, res_pay_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [START_W-1:0]  out_start_r, out_start_nxt;
  logic [PAY_W-1:0]    out_pay_r, out_pay_nxt;
  logic [CNT_W-1:0]    out_used_r, out_used_nxt;

  logic [7:0]          mem [MAP_BYTES];
  logic [7:0]          rd_data_r;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [7:0]          mem_wdata;

  logic [REQ_W-1:0]    in_bytes;
  logic [START_W-1:0]  in_fstart;
  logic [FPAY_W-1:0]   in_fpay;
  logic [PW-1:0]       prod;
  logic [7:0]          mask_v;
  logic [IW-1:0]       run_v;
  logic                found_v;
  logic [IW-1:0]       end_v;
  logic                issue;
  logic                pass_last;

  assign in_bytes  = in_tdata[12:0];
  assign in_fstart = in_tdata[22:13];
  assign in_fpay   = in_tdata[33:23];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_used_r, out_pay_r, out_start_r, out_status_r};

  // Ceiling division by the chunk size as a reciprocal multiply; exact for 13-bit operands.
  assign prod = PW'(num_r) * PW'(RECIP);

  assign rd_addr   = cnt_r[AW-1:0];
  assign issue     = (cnt_r <= last_r);
  assign pass_last = pend_r && ((AW + 1)'(pend_addr_r) == last_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Chunks of the byte in flight that fall inside the current run.
  always_comb begin
    logic [IW-1:0] c_m;
    for (int b = 0; b < 8; b++) begin
      c_m       = IW'({pend_addr_r, 3'(b)});
      mask_v[b] = (c_m >= lo_r) && (c_m <= hi_r);
    end
  end

  // Free-run counter over the eight chunks of the byte in flight. Chunks past
  // the end of the map count as used, so a run never crosses the bound.
  always_comb begin
    logic [IW-1:0] c_v;
    run_v   = run_r;
    found_v = 1'b0;
    end_v   = '0;
    for (int b = 0; b < 8; b++) begin
      c_v = IW'({pend_addr_r, 3'(b)});
      if (!rd_data_r[b] && (c_v < IW'(NUM_CHUNKS))) begin
        run_v = run_v + 1'b1;
        if ((run_v == total_r) && !found_v) begin
          found_v = 1'b1;
          end_v   = c_v;
        end
      end else begin
        run_v = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WIPE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r       <= last_nxt;
    pend_addr_r  <= pend_addr_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    run_r        <= run_nxt;
    total_r      <= total_nxt;
    num_r        <= num_nxt;
    pay_r        <= pay_nxt;
    op_r         <= op_nxt;
    fpay_r       <= fpay_nxt;
    bad_r        <= bad_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    res_pay_r    <= res_pay_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_pay_r    <= out_pay_nxt;
    out_used_r   <= out_used_nxt;
  end

  always_comb begin
    logic [IW-1:0]    hi_f;
    logic [IW-1:0]    lo_s;
    logic [REQ_W:0]   sum_v;

    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    last_nxt       = last_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = cnt_r[AW-1:0];
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    run_nxt        = run_r;
    total_nxt      = total_r;
    num_nxt        = num_r;
    pay_nxt        = pay_r;
    op_nxt         = op_r;
    fpay_nxt       = fpay_r;
    bad_nxt        = bad_r;
    used_nxt       = used_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    res_pay_nxt    = res_pay_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_pay_nxt    = out_pay_r;
    out_used_nxt   = out_used_r;
    in_tready      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = pend_addr_r;
    mem_wdata      = rd_data_r;
    hi_f           = IW'(in_fstart) + IW'(in_fpay) + IW'(HDR_CHUNKS) - 1'b1;
    lo_s           = end_v - total_r + 1'b1;
    sum_v          = (REQ_W + 1)'(used_r) + (REQ_W + 1)'(pay_r);

    // The four bitmap passes share one read pipe: issue byte cnt, handle it in the next cycle.
    if ((state_r == S_SCAN || state_r == S_VERIFY || state_r == S_SET || state_r == S_CLR)
        && issue) begin
      cnt_nxt  = cnt_r + 1'b1;
      pend_nxt = 1'b1;
    end

    case (state_r)
      S_WIPE: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        mem_wdata = '0;
        if (cnt_r == LAST_BYTE) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt        = in_tuser[0];
          fpay_nxt      = in_fpay;
          res_start_nxt = '0;
          res_pay_nxt   = '0;
          if (in_tuser[0] == OP_ALLOC) begin
            if ((in_bytes == '0) || (in_bytes > MAX_REQUEST)) begin
              res_status_nxt = STAT_BAD_REQ;
              state_nxt      = S_FINISH;
            end else begin
              num_nxt   = in_bytes + REQ_W'(CHUNK_BYTES - 1);
              state_nxt = S_DIV;
            end
          end else begin
            if ((in_fpay != '0) && (hi_f < IW'(NUM_CHUNKS))) begin
              lo_nxt    = IW'(in_fstart);
              hi_nxt    = hi_f;
              cnt_nxt   = (AW + 1)'(in_fstart >> 3);
              last_nxt  = hi_f[AW+3:3];
              bad_nxt   = 1'b0;
              state_nxt = S_VERIFY;
            end else begin
              res_status_nxt = STAT_BAD_FREE;
              state_nxt      = S_FINISH;
            end
          end
        end
      end
      S_DIV: begin
        pay_nxt   = prod[SHIFT +: REQ_W];
        state_nxt = S_PREP;
      end
      S_PREP: begin
        total_nxt = IW'(pay_r) + IW'(HDR_CHUNKS);
        run_nxt   = '0;
        cnt_nxt   = '0;
        last_nxt  = LAST_BYTE;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (pend_r) begin
          run_nxt = run_v;
          if (found_v) begin
            lo_nxt    = lo_s;
            hi_nxt    = end_v;
            cnt_nxt   = lo_s[AW+3:3];
            last_nxt  = end_v[AW+3:3];
            pend_nxt  = 1'b0;
            state_nxt = S_SET;
          end else if (pass_last) begin
            res_status_nxt = STAT_NO_SPACE;
            pend_nxt       = 1'b0;
            state_nxt      = S_FINISH;
          end
        end
      end
      S_VERIFY: begin
        if (pend_r) begin
          if ((rd_data_r & mask_v) != mask_v) begin
            bad_nxt = 1'b1;
          end
          if (pass_last) begin
            pend_nxt = 1'b0;
            if (bad_r || ((rd_data_r & mask_v) != mask_v)) begin
              res_status_nxt = STAT_BAD_FREE;
              state_nxt      = S_FINISH;
            end else begin
              cnt_nxt   = lo_r[AW+3:3];
              state_nxt = S_CLR;
            end
          end
        end
      end
      S_SET, S_CLR: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_wdata = (state_r == S_SET) ? (rd_data_r | mask_v) : (rd_data_r & ~mask_v);
          if (pass_last) begin
            pend_nxt       = 1'b0;
            res_status_nxt = STAT_OK;
            if (state_r == S_SET) begin
              res_start_nxt = lo_r[START_W-1:0];
              res_pay_nxt   = pay_r[PAY_W-1:0];
            end
            state_nxt = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          if (res_status_r == STAT_OK) begin
            if (op_r == OP_ALLOC) begin
              used_nxt = (sum_v > (REQ_W + 1)'(COUNT_MAX)) ? COUNT_MAX : sum_v[CNT_W-1:0];
            end else begin
              used_nxt = (used_r > fpay_r) ? (used_r - fpay_r) : '0;
            end
          end
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_start_nxt  = res_start_r;
          out_pay_nxt    = res_pay_r;
          out_used_nxt   = (res_status_r == STAT_OK) ? used_nxt : used_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/bffca_checker.sv @@
// Port checker for the bitmap first-fit chunk allocator, bound to its top level.
// Depends on bffca_pkg for field widths and status codes.
module bffca_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [bffca_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [0:0]                        in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [bffca_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bffca_pkg::*;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The bitmap wipe keeps the input closed right after reset.
  a_wipe_closed: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input open during bitmap wipe");

  // Every accepted item moves the sequencer out of S_IDLE, so ready drops after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while the first is in work");

  // A failed request carries no run.
  a_fail_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != STAT_OK) |-> out_tdata[22:2] == '0)
    else $error("failed request reports a run");

endmodule

bind bitmap_first_fit_chunk_allocator bffca_checker u_bffca_checker (.*);

@@ verif/tb.sv @@
// Self-checking testbench for bitmap_first_fit_chunk_allocator: directed and random
// allocate/free items, with a chunk-map predictor and a field-by-field result check.
// Depends on bffca_pkg and the allocator RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bffca_pkg::*;

  localparam int N_CHUNKS   = 1024;
  localparam int CHUNK_B    = 4;
  localparam int HDR_B      = 8;
  localparam int HDR_CHUNKS = (HDR_B + CHUNK_B - 1) / CHUNK_B;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 400;

  typedef struct packed {
    logic               op;
    logic [REQ_W-1:0]   bytes;
    logic [START_W-1:0] fstart;
    logic [FPAY_W-1:0]  fpay;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic [START_W-1:0] start;
    logic [PAY_W-1:0]   pay;
    logic [CNT_W-1:0]   used;
  } grant_t;

  typedef struct {
    int start;
    int pay;
  } run_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [0:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  bit [N_CHUNKS-1:0] chunk_map;
  int                used_chunks;
  request_t          pending[$];
  grant_t            grants_due[$];
  run_t              held_runs[$];
  request_t          in_flight;
  int                errors;
  bit                steady;
  int unsigned       cyc;

  bitmap_first_fit_chunk_allocator #(
    .NUM_CHUNKS  (N_CHUNKS),
    .CHUNK_BYTES (CHUNK_B),
    .HEADER_BYTES(HDR_B)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Applies one request to the shadow chunk map and returns the result it must produce.
  function automatic grant_t serve_request(request_t r);
    grant_t g;
    int     pay;
    int     total;
    int     run_len;
    int     s;
    int     c;
    bit     hit;
    g.status = STAT_OK;
    g.start  = '0;
    g.pay    = '0;
    if (r.op == OP_ALLOC) begin
      if (r.bytes == 0 || r.bytes > MAX_REQUEST) begin
        g.status = STAT_BAD_REQ;
      end else begin
        pay = (int'(r.bytes) + CHUNK_B - 1) / CHUNK_B;
        total = pay + HDR_CHUNKS;
        run_len = 0;
        hit = 1'b0;
        s = 0;
        for (c = 0; c < N_CHUNKS && !hit; c++) begin
          if (chunk_map[c]) run_len = 0;
          else run_len++;
          if (run_len == total) begin
            hit = 1'b1;
            s = c - total + 1;
          end
        end
        if (!hit) begin
          g.status = STAT_NO_SPACE;
        end else begin
          for (c = s; c < s + total; c++) chunk_map[c] = 1'b1;
          used_chunks = used_chunks + pay;
          if (used_chunks > int'(COUNT_MAX)) used_chunks = int'(COUNT_MAX);
          g.start = s[START_W-1:0];
          g.pay = pay[PAY_W-1:0];
          held_runs.push_back('{s, pay});
        end
      end
    end else begin
      s = int'(r.fstart);
      total = int'(r.fpay) + HDR_CHUNKS;
      hit = r.fpay != 0 && s + total <= N_CHUNKS;
      for (c = s; hit && c < s + total; c++) begin
        if (!chunk_map[c]) hit = 1'b0;
      end
      if (!hit) begin
        g.status = STAT_BAD_FREE;
      end else begin
        for (c = s; c < s + total; c++) chunk_map[c] = 1'b0;
        used_chunks = (used_chunks > int'(r.fpay)) ? used_chunks - int'(r.fpay) : 0;
        // Any tracked run touched by this free is no longer a valid target.
        for (c = held_runs.size() - 1; c >= 0; c--) begin
          if (held_runs[c].start < s + total &&
              held_runs[c].start + HDR_CHUNKS + held_runs[c].pay > s)
            held_runs.delete(c);
        end
      end
    end
    g.used = used_chunks[CNT_W-1:0];
    return g;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0d] mismatch: %s", cyc, what);
    errors++;
  endtask

  // The next request is chosen only once the previous one has been accepted,
  // so the generator always sees the up-to-date set of held runs.
  task automatic post_request(input logic op, input int bytes, input int fstart,
                              input int fpay);
    request_t r;
    while (pending.size() != 0 || in_tvalid) @(negedge clk);
    r.op = op;
    r.bytes = bytes[REQ_W-1:0];
    r.fstart = fstart[START_W-1:0];
    r.fpay = fpay[FPAY_W-1:0];
    pending.push_back(r);
  endtask

  task automatic wait_all_done();
    while (pending.size() != 0 || in_tvalid || grants_due.size() != 0) @(negedge clk);
  endtask

  task automatic post_alloc(input int bytes);
    post_request(OP_ALLOC, bytes, $urandom_range(1023), $urandom_range(2047));
  endtask

  task automatic post_free(input int fstart, input int fpay);
    post_request(OP_FREE, $urandom_range(8191), fstart, fpay);
  endtask

  // Driver: keeps the request stable until it is taken, idles at random between items unless steady.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) grants_due.push_back(serve_request(in_flight));
      if (!in_tvalid || in_tready) begin
        if (pending.size() != 0 && (steady || $urandom_range(99) >= 27)) begin
          in_flight = pending.pop_front();
          in_tdata <= {{(IN_TDATA_W - REQ_W - START_W - FPAY_W){1'b0}},
                       in_flight.fpay, in_flight.fstart, in_flight.bytes};
          in_tuser <= in_flight.op;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure unless steady, each taken result checked against the oldest expectation.
  always @(posedge clk) begin
    grant_t g;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 27);
      if (out_tvalid && out_tready) begin
        if (grants_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, tdata %h", out_tdata));
        end else begin
          g = grants_due.pop_front();
          if (out_tdata[1:0] != g.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_tdata[1:0], g.status));
          if (out_tdata[11:2] != g.start)
            report_mismatch($sformatf("run_start %0d, expected %0d", out_tdata[11:2], g.start));
          if (out_tdata[22:12] != g.pay)
            report_mismatch($sformatf("payload_chunks %0d, expected %0d",
                                      out_tdata[22:12], g.pay));
          if (out_tdata[33:23] != g.used)
            report_mismatch($sformatf("chunks_in_use %0d, expected %0d",
                                      out_tdata[33:23], g.used));
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    int   n;
    int   k;
    int   i;
    int   j;
    int   pick;
    bit   merged;
    run_t a;
    run_t b;
    run_t last_freed;
    chunk_map = '0;
    used_chunks = 0;
    errors = 0;
    steady = 1'b0;
    last_freed = '{0, 1};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: request limits, every rejection, first fit and a merged free.
    post_alloc(1);
    post_alloc(0);
    post_alloc(4097);
    post_alloc(8191);
    post_alloc(4096);
    post_free(0, 0);
    post_free(1023, 1);
    post_free(1023, 2047);
    post_free(3, 1);
    post_free(0, 1);
    post_free(0, 1);
    post_alloc(4088);
    post_alloc(1);
    post_free(0, 1022);
    post_alloc(40);
    post_alloc(4);
    // Frees both runs at once and takes more payload than is counted, so the count floors.
    post_free(0, 13);
    post_alloc(28);
    post_alloc(4);
    post_free(0, 7);
    post_alloc(8);
    post_alloc(20);
    post_free(1021, 1);
    post_free(9, 1);
    wait_all_done();

    for (n = 0; n < 400; n++) begin
      steady = (n >= 150 && n < 230);
      if (n % 100 == 99) wait_all_done();
      while (pending.size() != 0 || in_tvalid) @(negedge clk);
      k = $urandom_range(99);
      if (k < ((used_chunks > 600) ? 25 : 45)) begin
        k = $urandom_range(99);
        if (k < 70) post_alloc($urandom_range(1, 64));
        else if (k < 90) post_alloc($urandom_range(65, 1024));
        else if (k < 96) post_alloc($urandom_range(1025, 4096));
        else if (k < 98) post_alloc(0);
        else post_alloc($urandom_range(4097, 8191));
      end else if (k < 85 && held_runs.size() != 0) begin
        merged = 1'b0;
        if ($urandom_range(9) == 0) begin
          // Free two adjacent runs as one, with the split not matching either allocation.
          for (i = 0; i < held_runs.size() && !merged; i++) begin
            for (j = 0; j < held_runs.size() && !merged; j++) begin
              if (held_runs[i].start + HDR_CHUNKS + held_runs[i].pay == held_runs[j].start) begin
                a = held_runs[i];
                b = held_runs[j];
                merged = 1'b1;
              end
            end
          end
        end
        if (merged) begin
          post_free(a.start, a.pay + HDR_CHUNKS + b.pay);
        end else begin
          pick = $urandom_range(held_runs.size() - 1);
          last_freed = held_runs[pick];
          post_free(last_freed.start, last_freed.pay);
        end
      end else if (k < 90) begin
        post_free(last_freed.start, last_freed.pay);
      end else if (k < 95) begin
        post_free($urandom_range(1023), $urandom_range(2047));
      end else begin
        post_free($urandom_range(1023), $urandom_range(40));
      end
    end
    steady = 1'b0;

    wait_all_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ bitmap_first_fit_chunk_allocator.f @@
rtl/core/bffca_pkg.sv
rtl/core/bitmap_first_fit_chunk_allocator.sv
rtl/core/bffca_checker.sv
verif/tb.sv
